// ===== hdl/sbfd_pkg.sv =====
// Package for the SBUS frame decoder: frame constants, the frame event type
// passed from the assembler to the result emitter, and the footer check.
// No dependencies.
package sbfd_pkg;

  localparam int unsigned StoreDepth = 24;
  localparam int unsigned PosW       = 5;
  localparam int unsigned NumChan    = 16;
  localparam int unsigned ChanW      = 11;
  localparam int unsigned IdxW       = 4;

  localparam logic [PosW-1:0] FooterPos = 5'd24;
  localparam logic [PosW-1:0] IdlePos   = 5'd25;

  localparam logic [7:0] HeaderByte = 8'h0F;
  localparam logic [7:0] FooterA    = 8'h00;
  localparam logic [7:0] FooterB    = 8'h20;
  localparam logic [7:0] FooterC    = 8'h28;
  localparam logic [7:0] FooterD    = 8'h24;

  localparam logic [ChanW-1:0] BadCh0 = 11'h07C;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusFailLost = 2'd3;

  localparam logic [IdxW-1:0] LastChan = 4'd15;

  typedef logic [NumChan-1:0][ChanW-1:0] chan_vec_t;

  typedef struct packed {
    logic       valid;
    logic       framing_ok;
    logic       accept;
    logic [1:0] status;
    logic       dig_a;
    logic       dig_b;
    chan_vec_t  chans;
  } frame_evt_t;

  function automatic logic footer_ok(input logic [7:0] f);
    footer_ok = (f == FooterA) || (f == FooterB) || (f == FooterC) || (f == FooterD);
  endfunction

endpackage

// ===== hdl/sbus_frame_decoder.sv =====
// SBUS 16-channel frame decoder top level: byte assembler and result emitter.
// Depends on sbfd_pkg, sbfd_assembler and sbfd_emitter.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_stall_o | frame_byte_i, first_byte_i
//   out     | source    | out_valid_o/out_stall_i | accepted_o .. last_of_frame_o
//
// One byte beat is taken per cycle when not stalled. The footer beat loads a
// frame snapshot register, then the emitter sends one or sixteen result beats,
// one per cycle when not stalled, through its output register. The input stalls
// only at the footer position while the emitter is busy with the previous frame.
// Reset is asynchronous and active low; the decoder then waits for a first byte.
// A stalled output holds its beat while a new byte beat is still taken.
module sbus_frame_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        accepted_o,
  output logic        status_written_o,
  output logic [1:0]  signal_status_o,
  output logic [3:0]  channel_index_o,
  output logic [10:0] channel_value_o,
  output logic        digital_a_o,
  output logic        digital_b_o,
  output logic        last_of_frame_o
);

  sbfd_pkg::frame_evt_t evt;
  logic                 busy;

  sbfd_assembler u_assembler (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .first_byte_i (first_byte_i),
    .busy_i       (busy),
    .evt_o        (evt)
  );

  sbfd_emitter u_emitter (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .evt_i            (evt),
    .busy_o           (busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .status_written_o (status_written_o),
    .signal_status_o  (signal_status_o),
    .channel_index_o  (channel_index_o),
    .channel_value_o  (channel_value_o),
    .digital_a_o      (digital_a_o),
    .digital_b_o      (digital_b_o),
    .last_of_frame_o  (last_of_frame_o)
  );

endmodule

// ===== hdl/sbfd_assembler.sv =====
// Frame assembler: keeps bytes 0 to 23 of the frame in flip-flops, tracks the
// byte position and checks the frame when the footer beat arrives.
// Depends on sbfd_pkg.
module sbfd_assembler (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           frame_byte_i,
  input  logic                 first_byte_i,
  input  logic                 busy_i,
  output sbfd_pkg::frame_evt_t evt_o
);

  logic [sbfd_pkg::StoreDepth-1:0][7:0] store_q;
  logic [sbfd_pkg::PosW-1:0]            pos_q, pos_d, pos_eff;
  logic                                 take;
  logic                                 wr_en;
  logic [1:0]                           status;
  logic                                 framing_ok;
  logic                                 bad_pattern;
  sbfd_pkg::chan_vec_t                  chans;

  assign in_stall_o = busy_i && (pos_q == sbfd_pkg::FooterPos);
  assign take       = in_valid_i && !in_stall_o;
  assign pos_eff    = first_byte_i ? '0 : pos_q;
  assign wr_en      = take && (pos_eff < sbfd_pkg::FooterPos);

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      if (pos_eff < sbfd_pkg::FooterPos) begin
        pos_d = pos_eff + 5'd1;
      end else begin
        pos_d = sbfd_pkg::IdlePos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= sbfd_pkg::IdlePos;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[pos_eff] <= frame_byte_i;
    end
  end

  // Channel bits run LSB first through bytes 1 to 22.
  assign chans = store_q[22:1];

  assign status      = store_q[23][3:2];
  assign framing_ok  = (store_q[0] == sbfd_pkg::HeaderByte) && sbfd_pkg::footer_ok(frame_byte_i);
  assign bad_pattern = (chans[0] == sbfd_pkg::BadCh0) && (chans[1] == '0);

  always_comb begin
    evt_o.valid      = take && (pos_eff == sbfd_pkg::FooterPos);
    evt_o.framing_ok = framing_ok;
    evt_o.accept     = ((status == sbfd_pkg::StatusOk) || (status == sbfd_pkg::StatusFailLost))
                       && !bad_pattern;
    evt_o.status     = status;
    evt_o.dig_a      = store_q[23][0];
    evt_o.dig_b      = store_q[23][1];
    evt_o.chans      = chans;
  end

endmodule

// ===== hdl/sbfd_emitter.sv =====
// Result emitter: snapshots a checked frame and sends one or sixteen result
// beats through a registered output stage.
// Depends on sbfd_pkg.
module sbfd_emitter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbfd_pkg::frame_evt_t evt_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 accepted_o,
  output logic                 status_written_o,
  output logic [1:0]           signal_status_o,
  output logic [3:0]           channel_index_o,
  output logic [10:0]          channel_value_o,
  output logic                 digital_a_o,
  output logic                 digital_b_o,
  output logic                 last_of_frame_o
);

  logic                      busy_q, busy_d;
  logic [sbfd_pkg::IdxW-1:0] idx_q, idx_d;
  logic                      full_q;
  logic                      sw_q;
  logic [1:0]                st_q;
  logic                      da_q, db_q;
  sbfd_pkg::chan_vec_t       chans_q;

  logic                      out_valid_q, out_valid_d;
  logic                      acc_q, osw_q, oda_q, odb_q, olast_q;
  logic [1:0]                ost_q;
  logic [3:0]                oidx_q;
  logic [10:0]               oval_q;

  logic                      out_free;
  logic                      emit;
  logic                      last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign last     = !full_q || (idx_q == sbfd_pkg::LastChan);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (evt_i.valid) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (emit) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = busy_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (evt_i.valid) begin
      full_q  <= evt_i.framing_ok && evt_i.accept;
      sw_q    <= evt_i.framing_ok;
      st_q    <= evt_i.framing_ok ? evt_i.status : 2'd0;
      da_q    <= evt_i.dig_a;
      db_q    <= evt_i.dig_b;
      chans_q <= evt_i.chans;
    end
    if (emit) begin
      acc_q   <= full_q;
      osw_q   <= sw_q;
      ost_q   <= st_q;
      oidx_q  <= full_q ? idx_q : 4'd0;
      oval_q  <= full_q ? chans_q[idx_q] : 11'd0;
      oda_q   <= full_q && da_q;
      odb_q   <= full_q && db_q;
      olast_q <= last;
    end
  end

  assign busy_o           = busy_q;
  assign out_valid_o      = out_valid_q;
  assign accepted_o       = acc_q;
  assign status_written_o = osw_q;
  assign signal_status_o  = ost_q;
  assign channel_index_o  = oidx_q;
  assign channel_value_o  = oval_q;
  assign digital_a_o      = oda_q;
  assign digital_b_o      = odb_q;
  assign last_of_frame_o  = olast_q;

endmodule
